[rtl/core/c2d_pkg.sv]
// Shared constants and codes for the 5x5 convolution stream unit.
package c2d_pkg;

	localparam int IMAGE_SIZE_DEF   = 28;
	localparam int KERNEL_SIZE_DEF  = 5;
	localparam int FILTER_COUNT_DEF = 5;

	localparam int NUM_FEATURES = 5;
	localparam int FEATURE_W    = 28;
	localparam int POS_OUT_W    = 5;
	localparam int PIX_W        = 8;
	localparam int COEF_W       = 16;

	localparam logic [1:0] ACT_WEIGHT = 2'd0;
	localparam logic [1:0] ACT_BIAS   = 2'd1;
	localparam logic [1:0] ACT_PIXEL  = 2'd2;

	typedef logic [FEATURE_W-1:0] feature_t;

endpackage

[rtl/core/c2d_in_if.sv]
// Input stream channel: weight, bias and pixel beats.
interface c2d_in_if;
	import c2d_pkg::*;

	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic [2:0]         filter_sel;
	logic [4:0]         tap_index;
	logic signed [15:0] coefficient;
	logic [7:0]         pixel;
	logic               frame_start;

	modport source (output valid, action, filter_sel, tap_index, coefficient, pixel,
		frame_start, input ready);
	modport sink (input valid, action, filter_sel, tap_index, coefficient, pixel,
		frame_start, output ready);
endinterface

[rtl/core/c2d_out_if.sv]
// Result stream channel: window position and five ReLU features.
interface c2d_out_if;
	import c2d_pkg::*;

	logic        valid;
	logic        ready;
	logic [4:0]  out_row;
	logic [4:0]  out_col;
	feature_t    feature_a;
	feature_t    feature_b;
	feature_t    feature_c;
	feature_t    feature_d;
	feature_t    feature_e;
	logic        frame_last;

	modport source (output valid, out_row, out_col, feature_a, feature_b, feature_c,
		feature_d, feature_e, frame_last, input ready);
	modport sink (input valid, out_row, out_col, feature_a, feature_b, feature_c,
		feature_d, feature_e, frame_last, output ready);
endinterface

[rtl/core/conv2d_5x5_relu_stream_unit.sv]
// Streaming 5x5 valid convolution with ReLU over a raster pixel stream.
//
// Channel item: beats with action weight load one tap of one filter, bias
// load one filter bias, pixel beats carry the image in raster order, and
// frame_start on a pixel restarts at row 0, column 0.
// Channel result: one beat per pixel that completes a full window, with the
// window's top-left position, one feature per filter and frame_last on the
// last window of the image.
// Throughput: one beat of any kind per cycle while item.ready is high. A pixel's
// result passes through the product stage, which loads at the edge that takes
// its beat, then the row-sum stage and the output register. The line store is
// one wide memory, one column per entry, with the next column read ahead each
// cycle.
// Reset clears the position, weights, biases and pipeline valids; the line
// store needs no clearing since every window is rebuilt from rows of the
// current image before any result.
// A stalled result holds; the stages behind it keep filling and item.ready
// drops only once every stage holds a result.
module conv2d_5x5_relu_stream_unit #(
	parameter int IMAGE_SIZE   = c2d_pkg::IMAGE_SIZE_DEF,
	parameter int KERNEL_SIZE  = c2d_pkg::KERNEL_SIZE_DEF,
	parameter int FILTER_COUNT = c2d_pkg::FILTER_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	c2d_in_if.sink     item,
	c2d_out_if.source  result
);
	import c2d_pkg::*;

	localparam int K      = KERNEL_SIZE;
	localparam int F      = FILTER_COUNT;
	localparam int TAPS   = K * K;
	localparam int POS_W  = (IMAGE_SIZE > 1) ? $clog2(IMAGE_SIZE) : 1;
	localparam int SLOT_W = (K > 1) ? $clog2(K) : 1;
	localparam int MEM_W  = K * PIX_W;
	localparam int PROD_W = PIX_W + COEF_W + 1;
	localparam int ROW_W  = PROD_W + $clog2(K) + 1;
	localparam int SUM_W0 = PROD_W + $clog2(TAPS + 1) + 1;
	localparam int SUM_W  = (SUM_W0 > 30) ? SUM_W0 : 30;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(IMAGE_SIZE - 1);
	localparam logic [POS_W-1:0] FIRST_WIN = POS_W'(K - 1);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(K - 1);
	localparam logic signed [SUM_W-1:0] FEAT_MAX = SUM_W'((64'd1 << FEATURE_W) - 64'd1);

	logic [POS_W-1:0]  col_q, row_q;
	logic [SLOT_W-1:0] slot_q;
	logic [MEM_W-1:0]  line_mem [IMAGE_SIZE];
	logic [MEM_W-1:0]  rd_q;
	logic [PIX_W-1:0]  win_q [K][K];
	logic signed [COEF_W-1:0] weight_q [F][TAPS];
	logic signed [COEF_W-1:0] bias_q [F];

	logic v1_s1, v2_s2, v3_q;
	logic en1, en2, en3;
	logic signed [PROD_W-1:0] prod_s1 [F][TAPS];
	logic signed [COEF_W-1:0] bias_s1 [F];
	logic [POS_W-1:0] top_s1, left_s1;
	logic last_s1;
	logic signed [ROW_W-1:0] rsum_s2 [F][K];
	logic signed [COEF_W-1:0] bias_s2 [F];
	logic [POS_W-1:0] top_s2, left_s2;
	logic last_s2;
	feature_t feat_q [NUM_FEATURES];
	logic [POS_W-1:0] top_q, left_q;
	logic last_q;

	logic acc_in, is_pix, produce;
	logic [POS_W-1:0] cur_col, cur_row, nxt_col, nxt_row, rd_addr;
	logic [SLOT_W-1:0] cur_slot, nxt_slot;
	logic [MEM_W-1:0] wr_data;
	logic [PIX_W-1:0] colv [K];
	logic [PIX_W-1:0] win_next [K][K];
	logic signed [ROW_W-1:0] rsum_next [F][K];
	logic signed [SUM_W-1:0] total [F];
	feature_t feat_next [NUM_FEATURES];
	logic [POS_W+POS_OUT_W-1:0] top_ext, left_ext;

	assign en3 = !v3_q || result.ready;
	assign en2 = !v2_s2 || en3;
	assign en1 = !v1_s1 || en2;
	assign item.ready = en1;
	assign acc_in = item.valid && item.ready;
	assign is_pix = acc_in && (item.action == ACT_PIXEL);

	always_comb begin
		cur_col  = item.frame_start ? '0 : col_q;
		cur_row  = item.frame_start ? '0 : row_q;
		cur_slot = item.frame_start ? '0 : slot_q;
		nxt_col  = cur_col + POS_W'(1);
		nxt_row  = cur_row;
		nxt_slot = cur_slot;
		if (cur_col == LAST_POS) begin
			nxt_col = '0;
			if (cur_row == LAST_POS) begin
				nxt_row  = '0;
				nxt_slot = '0;
			end else begin
				nxt_row  = cur_row + POS_W'(1);
				nxt_slot = (cur_slot == LAST_SLOT) ? '0 : cur_slot + SLOT_W'(1);
			end
		end
		rd_addr = is_pix ? nxt_col : col_q;
		produce = is_pix && (cur_row >= FIRST_WIN) && (cur_col >= FIRST_WIN);
	end

	always_comb begin
		logic [SLOT_W:0] s;
		for (int i = 0; i < K; i++) begin
			wr_data[i*PIX_W +: PIX_W] = (SLOT_W'(i) == cur_slot) ? item.pixel
				: rd_q[i*PIX_W +: PIX_W];
		end
		for (int a = 0; a < K; a++) begin
			s = {1'b0, cur_slot} + (SLOT_W+1)'(1 + a);
			if (s >= (SLOT_W+1)'(K))
				s = s - (SLOT_W+1)'(K);
			colv[a] = wr_data[s[SLOT_W-1:0]*PIX_W +: PIX_W];
		end
		for (int a = 0; a < K; a++) begin
			for (int b = 0; b < K; b++) begin
				win_next[a][b] = (b < K - 1) ? win_q[a][(b + 1) % K] : colv[a];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_pix)
			line_mem[cur_col] <= wr_data;
		rd_q <= line_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
			for (int f = 0; f < F; f++) begin
				bias_q[f] <= '0;
				for (int t = 0; t < TAPS; t++)
					weight_q[f][t] <= '0;
			end
		end else if (acc_in) begin
			case (item.action)
				ACT_WEIGHT: begin
					for (int f = 0; f < F; f++)
						for (int t = 0; t < TAPS; t++)
							if (int'(item.filter_sel) == f && int'(item.tap_index) == t)
								weight_q[f][t] <= item.coefficient;
				end
				ACT_BIAS: begin
					for (int f = 0; f < F; f++)
						if (int'(item.filter_sel) == f)
							bias_q[f] <= item.coefficient;
				end
				ACT_PIXEL: begin
					col_q  <= nxt_col;
					row_q  <= nxt_row;
					slot_q <= nxt_slot;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (is_pix)
			for (int a = 0; a < K; a++)
				for (int b = 0; b < K; b++)
					win_q[a][b] <= win_next[a][b];
	end

	// stage 1: products
	always_ff @(posedge clk) begin
		if (en1) begin
			for (int f = 0; f < F; f++) begin
				bias_s1[f] <= bias_q[f];
				for (int a = 0; a < K; a++)
					for (int b = 0; b < K; b++)
						prod_s1[f][a*K+b] <= PROD_W'($signed({1'b0, win_next[a][b]})
							* weight_q[f][a*K+b]);
			end
			top_s1  <= cur_row - FIRST_WIN;
			left_s1 <= cur_col - FIRST_WIN;
			last_s1 <= (cur_row == LAST_POS) && (cur_col == LAST_POS);
		end
	end

	// stage 2: row sums
	always_comb begin
		for (int f = 0; f < F; f++)
			for (int a = 0; a < K; a++) begin
				rsum_next[f][a] = '0;
				for (int b = 0; b < K; b++)
					rsum_next[f][a] = rsum_next[f][a] + ROW_W'(prod_s1[f][a*K+b]);
			end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int f = 0; f < F; f++) begin
				bias_s2[f] <= bias_s1[f];
				for (int a = 0; a < K; a++)
					rsum_s2[f][a] <= rsum_next[f][a];
			end
			top_s2  <= top_s1;
			left_s2 <= left_s1;
			last_s2 <= last_s1;
		end
	end

	// stage 3: bias, ReLU, clamp
	always_comb begin
		for (int f = 0; f < F; f++) begin
			total[f] = {{(SUM_W-COEF_W-8){bias_s2[f][COEF_W-1]}}, bias_s2[f], 8'b0};
			for (int a = 0; a < K; a++)
				total[f] = total[f] + SUM_W'(rsum_s2[f][a]);
		end
		for (int g = 0; g < NUM_FEATURES; g++)
			feat_next[g] = '0;
		for (int f = 0; f < F; f++) begin
			if (total[f] < 0)
				feat_next[f] = '0;
			else if (total[f] > FEAT_MAX)
				feat_next[f] = '1;
			else
				feat_next[f] = total[f][FEATURE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			for (int g = 0; g < NUM_FEATURES; g++)
				feat_q[g] <= feat_next[g];
			top_q  <= top_s2;
			left_q <= left_s2;
			last_q <= last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_q  <= 1'b0;
		end else begin
			if (en1)
				v1_s1 <= produce;
			if (en2)
				v2_s2 <= v1_s1;
			if (en3)
				v3_q <= v2_s2;
		end
	end

	assign top_ext  = {{POS_OUT_W{1'b0}}, top_q};
	assign left_ext = {{POS_OUT_W{1'b0}}, left_q};

	assign result.valid      = v3_q;
	assign result.out_row    = top_ext[POS_OUT_W-1:0];
	assign result.out_col    = left_ext[POS_OUT_W-1:0];
	assign result.feature_a  = feat_q[0];
	assign result.feature_b  = feat_q[1];
	assign result.feature_c  = feat_q[2];
	assign result.feature_d  = feat_q[3];
	assign result.feature_e  = feat_q[4];
	assign result.frame_last = last_q;

endmodule

[tb/c2d_tb_pkg.sv]
`timescale 1ns / 1ps
// Shared testbench constants for the convolution stream unit.
package c2d_tb_pkg;
	localparam int IMG    = 28;
	localparam int KSZ    = 5;
	localparam int NFILT  = 5;
	localparam int NTAPS  = KSZ * KSZ;
	localparam logic [1:0] ACT_UNUSED = 2'd3;
endpackage

[tb/c2d_feature_checker.sv]
`timescale 1ns / 1ps
// Checker: watches both channels, predicts each window's features and compares.
module c2d_feature_checker (
	input  logic clk,
	input  logic arst_n,
	c2d_in_if    item,
	c2d_out_if   result,
	output int   fail_count,
	output int   pending,
	output int   windows_seen,
	output int   beats_taken
);
	import c2d_pkg::*;
	import c2d_tb_pkg::*;

	typedef struct {
		logic [4:0]  row;
		logic [4:0]  col;
		feature_t    feat [NUM_FEATURES];
		logic        last;
	} window_t;

	logic signed [15:0] weight_mem [NFILT][NTAPS];
	logic signed [15:0] bias_mem [NFILT];
	logic [7:0]         lines [KSZ][IMG];
	int                 cur_row;
	int                 cur_col;
	window_t            expected_windows [$];

	function automatic feature_t relu_sum(int f, int top, int left);
		longint acc;
		acc = longint'(bias_mem[f]) * 256;
		for (int a = 0; a < KSZ; a++)
			for (int b = 0; b < KSZ; b++)
				acc += longint'(lines[(top + a) % KSZ][left + b]) *
					longint'(weight_mem[f][a * KSZ + b]);
		if (acc < 0) acc = 0;
		if (acc > 268435455) acc = 268435455;
		return feature_t'(acc);
	endfunction

	task automatic take_beat();
		window_t w;
		case (item.action)
			ACT_WEIGHT: if (item.filter_sel < NFILT && item.tap_index < NTAPS)
				weight_mem[item.filter_sel][item.tap_index] = item.coefficient;
			ACT_BIAS: if (item.filter_sel < NFILT)
				bias_mem[item.filter_sel] = item.coefficient;
			ACT_PIXEL: begin
				if (item.frame_start) begin
					cur_row = 0;
					cur_col = 0;
				end
				lines[cur_row % KSZ][cur_col] = item.pixel;
				if (cur_row >= KSZ - 1 && cur_col >= KSZ - 1) begin
					w.row = 5'(cur_row - KSZ + 1);
					w.col = 5'(cur_col - KSZ + 1);
					for (int f = 0; f < NUM_FEATURES; f++)
						w.feat[f] = (f < NFILT) ? relu_sum(f, w.row, w.col) : '0;
					w.last = (cur_row == IMG - 1 && cur_col == IMG - 1);
					expected_windows.push_back(w);
				end
				cur_col++;
				if (cur_col >= IMG) begin
					cur_col = 0;
					cur_row = (cur_row + 1 >= IMG) ? 0 : cur_row + 1;
				end
			end
			default: ;
		endcase
	endtask

	task automatic compare_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	task automatic check_window();
		window_t w;
		feature_t got [NUM_FEATURES];
		got = '{result.feature_a, result.feature_b, result.feature_c,
			result.feature_d, result.feature_e};
		windows_seen++;
		if (expected_windows.size() == 0) begin
			$error("unexpected result beat at row %0d col %0d",
				result.out_row, result.out_col);
			fail_count++;
			return;
		end
		w = expected_windows.pop_front();
		compare_field("out_row", w.row, result.out_row);
		compare_field("out_col", w.col, result.out_col);
		for (int f = 0; f < NUM_FEATURES; f++)
			compare_field($sformatf("feature_%c", 8'h61 + f), w.feat[f], got[f]);
		compare_field("frame_last", w.last, result.frame_last);
	endtask

	initial begin
		fail_count = 0;
		windows_seen = 0;
		beats_taken = 0;
		cur_row = 0;
		cur_col = 0;
		for (int f = 0; f < NFILT; f++) begin
			bias_mem[f] = '0;
			for (int t = 0; t < NTAPS; t++) weight_mem[f][t] = '0;
		end
		for (int r = 0; r < KSZ; r++)
			for (int c = 0; c < IMG; c++) lines[r][c] = '0;
	end

	assign pending = expected_windows.size();

	always @(posedge clk) begin
		if (arst_n) begin
			if (result.valid && result.ready) check_window();
			if (item.valid && item.ready) begin
				take_beat();
				beats_taken++;
			end
		end
	end
endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Top: drives weight, bias and pixel beats into the unit and gives the verdict.
module testbench;
	import c2d_pkg::*;
	import c2d_tb_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   windows_seen;
	int   beats_taken;
	int   src_idle_pct;
	int   snk_stall_pct;
	bit   snk_hold;
	int   hold_cycles;
	int   quiet_cycles;

	c2d_in_if  item ();
	c2d_out_if result ();

	conv2d_5x5_relu_stream_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result)
	);

	c2d_feature_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.result       (result),
		.fail_count   (fail_count),
		.pending      (pending),
		.windows_seen (windows_seen),
		.beats_taken  (beats_taken)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Receiver: random stall, or a long hold counted here.
	initial begin
		result.ready = 1'b0;
		hold_cycles = 0;
		forever begin
			@(negedge clk);
			if (snk_hold && hold_cycles < 300) begin
				hold_cycles++;
				result.ready <= 1'b0;
			end else begin
				if (!snk_hold) hold_cycles = 0;
				result.ready <= arst_n && ($urandom_range(99) >= snk_stall_pct);
			end
		end
	end

	// Watchdog: count cycles with no beat on either channel.
	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((item.valid && item.ready) || (result.valid && result.ready))
				quiet_cycles = 0;
			else if (arst_n && !(snk_hold && hold_cycles < 300))
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic send_beat(logic [1:0] act, logic [2:0] fsel, logic [4:0] tap,
		logic [15:0] coef, logic [7:0] pix, logic fstart);
		while ($urandom_range(99) < src_idle_pct) begin
			item.valid <= 1'b0;
			@(negedge clk);
		end
		item.valid       <= 1'b1;
		item.action      <= act;
		item.filter_sel  <= fsel;
		item.tap_index   <= tap;
		item.coefficient <= coef;
		item.pixel       <= pix;
		item.frame_start <= fstart;
		do @(posedge clk); while (!item.ready);
		@(negedge clk);
	endtask

	function automatic logic [15:0] rand_coef(int mode);
		case (mode)
			0: return 16'h7fff;
			1: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	// mode 3: largest taps on even filters, most negative on odd ones
	task automatic load_filters(int mode);
		for (int f = 0; f < NFILT; f++) begin
			int m;
			m = (mode == 3) ? f % 2 : mode;
			for (int t = 0; t < NTAPS; t++)
				send_beat(ACT_WEIGHT, 3'(f), 5'(t), rand_coef(m),
					8'($urandom), 1'($urandom));
			send_beat(ACT_BIAS, 3'(f), 5'($urandom), rand_coef(m),
				8'($urandom), 1'($urandom));
		end
	endtask

	task automatic send_noise();
		case ($urandom_range(3))
			0: send_beat(ACT_UNUSED, 3'($urandom), 5'($urandom), 16'($urandom),
				8'($urandom), 1'($urandom));
			1: send_beat(ACT_WEIGHT, 3'($urandom_range(7, 5)), 5'($urandom),
				16'($urandom), 8'($urandom), 1'($urandom));
			2: send_beat(ACT_WEIGHT, 3'($urandom_range(4)), 5'($urandom_range(31, 25)),
				16'($urandom), 8'($urandom), 1'($urandom));
			default: send_beat(ACT_BIAS, 3'($urandom_range(7, 5)), 5'($urandom),
				16'($urandom), 8'($urandom), 1'($urandom));
		endcase
	endtask

	// start_at: index of the pixel that carries frame_start, -1 for none
	task automatic send_pixels(int pix_mode, int count, int start_at);
		logic [7:0] p;
		for (int i = 0; i < count; i++) begin
			case (pix_mode)
				0: p = 8'hff;
				1: p = 8'h00;
				default: p = 8'($urandom);
			endcase
			send_beat(ACT_PIXEL, 3'($urandom), 5'($urandom), 16'($urandom), p,
				i == start_at);
		end
	endtask

	task automatic drain();
		item.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	initial begin
		item.valid = 1'b0;
		item.action = ACT_PIXEL;
		item.filter_sel = '0;
		item.tap_index = '0;
		item.coefficient = '0;
		item.pixel = '0;
		item.frame_start = 1'b0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		snk_hold = 1'b0;
		wait (arst_n);
		@(negedge clk);

		// directed: extreme weights, odd loads, short partial frame
		send_noise();
		send_noise();
		send_beat(ACT_WEIGHT, 3'd0, 5'd0, 16'h7fff, 8'h00, 1'b0);
		send_beat(ACT_WEIGHT, 3'd4, 5'd24, 16'h8000, 8'hff, 1'b1);
		send_beat(ACT_BIAS, 3'd1, 5'd0, 16'h7fff, 8'h00, 1'b0);
		send_beat(ACT_BIAS, 3'd2, 5'd31, 16'h8000, 8'hff, 1'b1);
		for (int i = 0; i < 12; i++)
			send_beat(ACT_PIXEL, 3'd0, 5'd0, 16'h0, 8'hff, i == 0);
		load_filters(3);
		send_pixels(0, 5 * IMG, 0);
		drain();

		// one full image spread over the idling phases
		load_filters(2);
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin src_idle_pct = 0; snk_stall_pct = 0; end
				1: begin src_idle_pct = 62; snk_stall_pct = 0; end
				2: begin src_idle_pct = 0; snk_stall_pct = 62; end
				default: begin src_idle_pct = 7; snk_stall_pct = 7; end
			endcase
			send_noise();
			send_pixels(2, IMG * IMG / 4, (ph == 0) ? 0 : -1);
			drain();
		end
		src_idle_pct = 0;
		snk_stall_pct = 0;

		// overrun into the next image while the receiver holds off
		snk_hold = 1'b1;
		send_pixels(2, 130, -1);
		snk_hold = 1'b0;
		drain();

		// restart in mid-image
		send_pixels(1, 140, 10);
		drain();

		$display("Run took %0d input beats and checked %0d windows,", beats_taken,
			windows_seen);
		$display("covering extreme and random taps, ignored loads, restarts, wrap and stalls.");
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

[conv2d_5x5_relu_stream_unit.f]
rtl/core/c2d_pkg.sv
rtl/core/c2d_in_if.sv
rtl/core/c2d_out_if.sv
rtl/core/conv2d_5x5_relu_stream_unit.sv
tb/c2d_tb_pkg.sv
tb/c2d_feature_checker.sv
tb/testbench.sv
